[src/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the date-time digit field parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

	localparam int FIELD_BITS_DEF = 16;
	localparam int NUM_FIELDS     = 6;
	localparam int IDX_BITS       = 3;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_FIELDS - 1);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_RUN  = 4'b0010,
		PH_SKIP = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

[src/dtp_digit_acc.sv]
// ----------------------------------------------------------------------------
// dtp_digit_acc
// Saturating decimal accumulate: acc * 10 + digit, clipped at all ones.
// ----------------------------------------------------------------------------
module dtp_digit_acc #(
	parameter int FIELD_BITS = dtp_pkg::FIELD_BITS_DEF
) (
	input  logic [FIELD_BITS-1:0] acc,
	input  logic [7:0]            char_code,
	output logic [FIELD_BITS-1:0] acc_next
);

	localparam int WIDE = FIELD_BITS + 4;

	logic [WIDE-1:0] acc_w;
	logic [WIDE-1:0] sum_w;
	logic [3:0]      digit;

	assign digit = 4'(char_code - dtp_pkg::CH_ZERO);
	assign acc_w = WIDE'(acc);
	// times ten as two shifts
	assign sum_w = (acc_w << 3) + (acc_w << 1) + WIDE'(digit);
	assign acc_next = (|sum_w[WIDE-1:FIELD_BITS]) ? '1 : sum_w[FIELD_BITS-1:0];

endmodule

[src/datetime_digit_field_parser.sv]
// ----------------------------------------------------------------------------
// datetime_digit_field_parser
// Collects six decimal digit runs (year .. second) from a zero-terminated
// byte stream and reports success or failure once per settled string.
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | content
//  --------+------------------------------+-----------+------------------------
//  in      | in_valid, in_ready           | sink      | char_code
//  out     | out_valid, out_ready         | source    | ok, year .. second
//
// one byte per cycle while in_ready is high; the parse state updates on the byte
// transfer and any verdict lands in the result register at that same edge, so
// out_valid rises in the cycle after the byte that settles the string
// in_ready is high whenever the result register is empty or being drained,
// so a stalled output holds off input only while a verdict waits
// reset clears the parse state, the field store and the result valid flag
module datetime_digit_field_parser #(
	parameter int FIELD_BITS = dtp_pkg::FIELD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_code,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ok,
	output logic [FIELD_BITS-1:0] year,
	output logic [FIELD_BITS-1:0] month,
	output logic [FIELD_BITS-1:0] day,
	output logic [FIELD_BITS-1:0] hour,
	output logic [FIELD_BITS-1:0] minute,
	output logic [FIELD_BITS-1:0] second
);

	localparam int NF = dtp_pkg::NUM_FIELDS;
	localparam int IB = dtp_pkg::IDX_BITS;

	dtp_pkg::phase_t       phase_q, phase_n;
	logic [FIELD_BITS-1:0] acc_q, acc_n;
	logic [IB-1:0]         count_q, count_n;
	logic [FIELD_BITS-1:0] store_q [NF];
	logic [FIELD_BITS-1:0] store_n [NF];

	logic                  res_valid_q;
	logic                  res_ok_q;
	logic [FIELD_BITS-1:0] res_field_q [NF];

	logic                  xfer;
	logic                  emit;
	logic                  emit_ok;
	logic                  digit;
	logic                  nul;
	logic [IB-1:0]         idx;
	logic [FIELD_BITS-1:0] acc_base;
	logic [FIELD_BITS-1:0] acc_add;

	assign in_ready = !res_valid_q || out_ready;
	assign xfer     = in_valid && in_ready;
	assign digit    = dtp_pkg::is_digit(char_code);
	assign nul      = (char_code == dtp_pkg::CH_NUL);
	assign idx      = (count_q > dtp_pkg::LAST_IDX) ? dtp_pkg::LAST_IDX : count_q;

	// a new run starts from zero
	assign acc_base = (phase_q == dtp_pkg::PH_RUN) ? acc_q : '0;

	dtp_digit_acc #(
		.FIELD_BITS(FIELD_BITS)
	) u_acc (
		.acc      (acc_base),
		.char_code(char_code),
		.acc_next (acc_add)
	);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		count_n = count_q;
		store_n = store_q;
		emit    = 1'b0;
		emit_ok = 1'b0;
		case (phase_q)
			dtp_pkg::PH_IDLE: begin
				for (int i = 0; i < NF; i++) begin
					store_n[i] = '0;
				end
				acc_n   = '0;
				count_n = '0;
				if (nul) begin
					emit = 1'b1;
				end else if (!digit) begin
					phase_n = dtp_pkg::PH_DONE;
					emit    = 1'b1;
				end else begin
					acc_n   = acc_add;
					phase_n = dtp_pkg::PH_RUN;
				end
			end
			dtp_pkg::PH_RUN: begin
				if (digit) begin
					acc_n = acc_add;
				end else if (nul) begin
					phase_n = dtp_pkg::PH_IDLE;
					emit    = 1'b1;
					if (idx == dtp_pkg::LAST_IDX) begin
						store_n[idx] = acc_q;
						emit_ok      = 1'b1;
					end
				end else begin
					store_n[idx] = acc_q;
					if (idx == dtp_pkg::LAST_IDX) begin
						phase_n = dtp_pkg::PH_DONE;
						emit    = 1'b1;
						emit_ok = 1'b1;
					end else begin
						count_n = idx + IB'(1);
						phase_n = dtp_pkg::PH_SKIP;
					end
				end
			end
			dtp_pkg::PH_SKIP: begin
				if (nul) begin
					phase_n = dtp_pkg::PH_IDLE;
					emit    = 1'b1;
				end else if (digit) begin
					acc_n   = acc_add;
					phase_n = dtp_pkg::PH_RUN;
				end
			end
			dtp_pkg::PH_DONE: begin
				if (nul) begin
					phase_n = dtp_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_n = dtp_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtp_pkg::PH_IDLE;
			acc_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < NF; i++) begin
				store_q[i] <= '0;
			end
		end else if (xfer) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			count_q <= count_n;
			store_q <= store_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (xfer) begin
			res_valid_q <= emit;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only on a transfer that gives a verdict
	always_ff @(posedge clk) begin
		if (xfer && emit) begin
			res_ok_q    <= emit_ok;
			res_field_q <= store_n;
		end
	end

	assign out_valid = res_valid_q;
	assign ok        = res_ok_q;
	assign year      = res_field_q[0];
	assign month     = res_field_q[1];
	assign day       = res_field_q[2];
	assign hour      = res_field_q[3];
	assign minute    = res_field_q[4];
	assign second    = res_field_q[5];

endmodule
